### sv/usd_pkg.sv
package usd_pkg;

  localparam int unsigned MAX_SEQ_LEN_DEF = 4;
  localparam int unsigned CODE_W          = 21;
  localparam int unsigned COUNT_W         = 3;

  localparam logic [7:0] LEAD_MIN  = 8'hC0;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] PAY_MASK  = 8'h3F;
  localparam logic [7:0] LEAD_MASK = 8'h7F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code_point;
    logic [COUNT_W-1:0] byte_count;
    logic               last_of_run;
  } out_item_t;

  // Kind of the closing result of a transaction
  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_RAW  = 2'd1,
    FIN_DEC  = 2'd2
  } fin_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } usd_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic step;
  } usd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic multi;
    logic last_item;
    logic out_free;
  } usd_sts_t;

  // Count of leading one bits of a byte, 0..8
  function automatic logic [3:0] lead_ones(logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = '0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage

### sv/usd_ctrl.sv
module usd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  usd_pkg::usd_sts_t sts_i,
  output usd_pkg::usd_cmd_t cmd_o
);
  import usd_pkg::*;

  usd_state_e state_q, state_d;

  assign in_stall_o = !((state_q == ST_IDLE) && sts_i.out_free);
  assign cmd_o.accept = in_valid_i && !in_stall_o;
  assign cmd_o.step   = (state_q == ST_EMIT) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && sts_i.multi) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.step && sts_i.last_item) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/usd_dp.sv
module usd_dp #(
  parameter int unsigned MAX_SEQ_LEN = usd_pkg::MAX_SEQ_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  usd_pkg::usd_cmd_t  cmd_i,
  output usd_pkg::usd_sts_t  sts_o,
  input  usd_pkg::in_item_t  in_data_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output usd_pkg::out_item_t out_data_o
);
  import usd_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_SEQ_LEN + 1);
  localparam int unsigned HELD   = MAX_SEQ_LEN - 1;
  localparam int unsigned HIDX_W = (HELD > 1) ? $clog2(HELD) : 1;

  // sequence state
  logic [7:0]        lead_q, lead_d;
  logic [CNT_W-1:0]  exp_q, exp_d;
  logic [CNT_W-1:0]  bc_q, bc_d;
  logic [CODE_W-1:0] partial_q, partial_d;
  logic [7:0]        held_q [HELD];

  // per-transaction replay state
  logic [7:0]        byte_q;
  fin_e              fin_q;
  logic [CNT_W-1:0]  flush_n_q, total_q, idx_q;
  logic [CODE_W-1:0] dec_code_q;
  logic [CNT_W-1:0]  dec_cnt_q;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [7:0]        b;
  logic              last_b;
  logic [3:0]        ones;
  logic              pending, cont, complete, fresh_start, cont_path, flush, store;
  fin_e              fin;
  logic [CNT_W-1:0]  flush_n, total, wr_slot, rd_slot;
  logic [CODE_W-1:0] dec_code;

  assign b        = in_data_i.data_byte;
  assign last_b   = in_data_i.end_of_stream;
  assign ones     = lead_ones(b);
  assign pending  = (exp_q != '0);
  assign cont     = ((b & CONT_MASK) == CONT_TAG);
  assign complete = ({1'b0, bc_q} + {{CNT_W{1'b0}}, 1'b1}) >= {1'b0, exp_q};
  assign fresh_start = (b >= LEAD_MIN) && (ones <= 4'(MAX_SEQ_LEN)) && !last_b;
  assign cont_path   = pending && cont;
  assign flush       = pending && (!cont || (!complete && last_b));
  assign store       = cont_path && !complete && !last_b;
  assign dec_code    = {partial_q[CODE_W-7:0], b[5:0]};

  always_comb begin
    if (cont_path) begin
      if (complete)    fin = FIN_DEC;
      else if (last_b) fin = FIN_RAW;
      else             fin = FIN_NONE;
    end else begin
      fin = fresh_start ? FIN_NONE : FIN_RAW;
    end
  end

  assign flush_n = flush ? bc_q : '0;
  assign total   = flush_n + ((fin != FIN_NONE) ? CNT_W'(1) : CNT_W'(0));
  assign wr_slot = bc_q - CNT_W'(1);
  assign rd_slot = idx_q - CNT_W'(1);

  assign sts_o.multi     = (total > CNT_W'(1));
  assign sts_o.last_item = (idx_q == (total_q - CNT_W'(1)));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // sequence state update on accept
  always_comb begin
    lead_d    = lead_q;
    exp_d     = exp_q;
    bc_d      = bc_q;
    partial_d = partial_q;
    if (cmd_i.accept) begin
      if (store) begin
        bc_d      = bc_q + CNT_W'(1);
        partial_d = dec_code;
      end else if (cont_path || !fresh_start) begin
        exp_d     = '0;
        bc_d      = '0;
        partial_d = '0;
      end else begin
        lead_d    = b;
        exp_d     = CNT_W'(ones);
        bc_d      = CNT_W'(1);
        partial_d = CODE_W'(b & (LEAD_MASK >> ones));
      end
    end
  end

  // output register load
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.accept && (total != '0)) begin
      out_valid_d = 1'b1;
      if (flush_n != '0) begin
        out_d.code_point  = CODE_W'(lead_q);
        out_d.byte_count  = COUNT_W'(1);
        out_d.last_of_run = (total == CNT_W'(1));
      end else if (fin == FIN_DEC) begin
        out_d.code_point  = dec_code;
        out_d.byte_count  = COUNT_W'(exp_q);
        out_d.last_of_run = 1'b1;
      end else begin
        out_d.code_point  = CODE_W'(b);
        out_d.byte_count  = COUNT_W'(1);
        out_d.last_of_run = 1'b1;
      end
    end else if (cmd_i.step) begin
      out_valid_d       = 1'b1;
      out_d.last_of_run = sts_o.last_item;
      if (idx_q < flush_n_q) begin
        out_d.code_point = CODE_W'(held_q[rd_slot[HIDX_W-1:0]]);
        out_d.byte_count = COUNT_W'(1);
      end else if (fin_q == FIN_DEC) begin
        out_d.code_point = dec_code_q;
        out_d.byte_count = COUNT_W'(dec_cnt_q);
      end else begin
        out_d.code_point = CODE_W'(byte_q);
        out_d.byte_count = COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q      <= '0;
      exp_q       <= '0;
      bc_q        <= '0;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
      fin_q       <= FIN_NONE;
      flush_n_q   <= '0;
      total_q     <= '0;
      idx_q       <= '0;
    end else begin
      lead_q      <= lead_d;
      exp_q       <= exp_d;
      bc_q        <= bc_d;
      partial_q   <= partial_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.accept) begin
        fin_q     <= fin;
        flush_n_q <= flush_n;
        total_q   <= total;
        idx_q     <= CNT_W'(1);
      end else if (cmd_i.step) begin
        idx_q     <= idx_q + CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.accept) begin
      byte_q     <= b;
      dec_code_q <= dec_code;
      dec_cnt_q  <= exp_q;
    end
  end

  // continuation holding store
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && store && (wr_slot < CNT_W'(HELD))) begin
      held_q[wr_slot[HIDX_W-1:0]] <= b;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/utf8_stream_decoder_core.sv
// UTF-8 stream decoder.
// Input channel (in_valid_i / in_stall_o / in_data_i): one text byte per
// transaction, with end_of_stream on the final byte of a buffer.
// Output channel (out_valid_o / out_stall_i / out_data_o): one code point per
// transaction with the number of stream bytes it covers; last_of_run marks the
// final result caused by an input byte. Some bytes (continuations still being
// collected, a fresh lead byte) cause no result at all.
// A result shows on the output in the cycle after its input transaction.
// Throughput: one byte per cycle while each byte causes at most one result
// and the receiver does not stall. A broken or unfinished sequence replays
// its lead and held continuations as raw bytes, one per cycle from the output
// register unless the receiver stalls; the input is stalled during the replay.
// Reset clears the pending sequence and the output valid flag; input is
// accepted as soon as reset is released. When the receiver stalls, the output
// register holds its transaction and the input is stalled as well.
module utf8_stream_decoder_core #(
  parameter int unsigned MAX_SEQ_LEN = usd_pkg::MAX_SEQ_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  usd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output usd_pkg::out_item_t out_data_o
);
  import usd_pkg::*;

  usd_cmd_t cmd;
  usd_sts_t sts;

  // controller: accept / replay sequencing
  usd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: sequence state, held bytes, output register
  usd_dp #(
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

### sv/usd_checker.sv
module usd_checker #(
  parameter int unsigned MAX_SEQ_LEN = usd_pkg::MAX_SEQ_LEN_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input usd_pkg::out_item_t out_data_o
);
  import usd_pkg::*;

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // byte count within sequence range
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_count != '0) &&
                    (out_data_o.byte_count <= COUNT_W'(MAX_SEQ_LEN)))
    else $error("byte count out of range");

  // a decoded sequence is always the last result of its input byte
  a_multi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.byte_count != COUNT_W'(1)) |-> out_data_o.last_of_run)
    else $error("multi-byte result not last of run");

  // mid-replay the input side is held off
  a_replay_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> in_stall_o)
    else $error("input accepted during replay");

  // a raw byte result carries a byte value
  a_raw_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.byte_count == COUNT_W'(1)) |->
      (out_data_o.code_point[CODE_W-1:8] == '0))
    else $error("raw result wider than a byte");

endmodule

bind utf8_stream_decoder_core usd_checker #(
  .MAX_SEQ_LEN (MAX_SEQ_LEN)
) u_usd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### tb/usd_result_checker.sv
module usd_result_checker #(
  parameter int unsigned MAX_SEQ_LEN = usd_pkg::MAX_SEQ_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  usd_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  usd_pkg::out_item_t out_data_i,
  output int unsigned        err_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);
  import usd_pkg::*;

  localparam int unsigned HOLD_DEPTH = MAX_SEQ_LEN - 1;

  // decoder state mirror
  logic [7:0]        lead_q;
  int unsigned       seq_len_q;   // 0: no sequence open
  int unsigned       seq_got_q;   // bytes taken so far, lead included
  logic [7:0]        held_q [HOLD_DEPTH];
  logic [CODE_W-1:0] acc_q;

  out_item_t   step_q [$];        // results of the byte being decoded
  out_item_t   pending_points_q [$];
  out_item_t   want;
  int unsigned fails;
  int unsigned checked;

  function automatic int unsigned lead_run(logic [7:0] b);
    int unsigned n;
    n = 0;
    while (n < 8 && b[7-n]) n++;
    return n;
  endfunction

  function automatic out_item_t raw_result(logic [7:0] b);
    return out_item_t'{code_point: CODE_W'(b), byte_count: COUNT_W'(1), last_of_run: 1'b0};
  endfunction

  task automatic close_seq();
    seq_len_q = 0;
    seq_got_q = 0;
    acc_q     = '0;
  endtask

  // lead and held continuations go out as raw bytes
  task automatic flush_open_seq();
    step_q.push_back(raw_result(lead_q));
    for (int unsigned i = 0; i + 1 < seq_got_q && i < HOLD_DEPTH; i++) begin
      step_q.push_back(raw_result(held_q[i]));
    end
  endtask

  task automatic start_or_pass(logic [7:0] b, logic eos);
    int unsigned ones;
    ones = lead_run(b);
    if (b < LEAD_MIN || ones > MAX_SEQ_LEN || eos) begin
      step_q.push_back(raw_result(b));
    end else begin
      lead_q    = b;
      seq_len_q = ones;
      seq_got_q = 1;
      acc_q     = CODE_W'(b & (LEAD_MASK >> ones));
    end
  endtask

  task automatic decode_byte(in_item_t item);
    logic [7:0] b;
    logic       eos;
    b   = item.data_byte;
    eos = item.end_of_stream;
    step_q.delete();
    if (seq_len_q != 0) begin
      if ((b & CONT_MASK) == CONT_TAG) begin
        acc_q = {acc_q[CODE_W-7:0], b[5:0]};
        if (seq_got_q + 1 >= seq_len_q) begin
          step_q.push_back(out_item_t'{code_point: acc_q, byte_count: COUNT_W'(seq_len_q),
                                       last_of_run: 1'b0});
          close_seq();
        end else if (eos) begin
          flush_open_seq();
          step_q.push_back(raw_result(b));
          close_seq();
        end else begin
          if (seq_got_q - 1 < HOLD_DEPTH) held_q[seq_got_q-1] = b;
          seq_got_q++;
        end
      end else begin
        flush_open_seq();
        close_seq();
        start_or_pass(b, eos);
      end
    end else begin
      start_or_pass(b, eos);
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last_of_run = 1'b1;
    foreach (step_q[i]) pending_points_q.push_back(step_q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q = '0;
      foreach (held_q[i]) held_q[i] = '0;
      close_seq();
      pending_points_q.delete();
      fails   = 0;
      checked = 0;
      err_count_o <= 0;
      pending_o   <= 0;
      checked_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_points_q.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected result: cp=%h cnt=%0d last=%0d",
                     out_data_i.code_point, out_data_i.byte_count, out_data_i.last_of_run);
          end
          fails++;
        end else begin
          want = pending_points_q.pop_front();
          checked++;
          if (out_data_i.code_point  !== want.code_point ||
              out_data_i.byte_count  !== want.byte_count ||
              out_data_i.last_of_run !== want.last_of_run) begin
            if (fails < 10) begin
              $display("mismatch: expected cp=%h cnt=%0d last=%0d, got cp=%h cnt=%0d last=%0d",
                       want.code_point, want.byte_count, want.last_of_run,
                       out_data_i.code_point, out_data_i.byte_count, out_data_i.last_of_run);
            end
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
      err_count_o <= fails;
      pending_o   <= pending_points_q.size();
      checked_o   <= checked;
    end
  end

endmodule

### tb/tb_top.sv
module tb_top;
  import usd_pkg::*;

  // Generous ceiling: ~170 bytes, each with sender idle cycles, up to four
  // results and heavy receiver stalls.
  localparam int unsigned CYCLE_LIMIT = 200_000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int unsigned err_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles     = 0;
  int unsigned bytes_sent = 0;

  // idle percentages, changed per phase by the stimulus
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Edge cases, {end_of_stream, data_byte}
  logic [8:0] edge_cases [$] = '{
    9'h000,                       // lowest byte
    9'h0FF,                       // eight leading ones: lead too long, raw
    9'h080,                       // stray continuation passes raw
    9'h0C0, 9'h080,               // overlong two-byte form of code point zero
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, // largest value of the four-byte form
    9'h0E2, 9'h082, 9'h0AC,       // plain three-byte sequence
    9'h0F8,                       // five leading ones: too long, raw
    9'h1C3,                       // lead on the final byte goes out raw
    9'h0E2, 9'h041,               // bad continuation right after the lead
    9'h0F0, 9'h09F, 9'h0C3, 9'h0A9, // bad continuation that is itself a lead
    9'h0F0, 9'h09F, 9'h098, 9'h141, // lead and two held bytes flushed, then ASCII
    9'h0E2, 9'h182                // stream ends before the sequence completes
  };

  utf8_stream_decoder_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  usd_result_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle independent of out_valid.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // One input transaction: optional idle cycles, then hold the byte until
  // the block takes it. in_valid gets a single NBA per time step.
  task automatic send_byte(logic [7:0] b, logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{data_byte: b, end_of_stream: eos};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  function automatic logic rare_eos();
    return ($urandom_range(15) == 0);
  endfunction

  // Hold off the sender until every predicted result has come out. The first
  // edge lets the checker count the last accepted byte.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One random unit of text. Well-formed sequences with random payload are the
  // largest share; the rest is ASCII, broken or cut-short sequences, and noise.
  task automatic send_random_unit();
    int unsigned pick;
    int unsigned len;
    int unsigned keep;
    logic [7:0]  lead;
    logic [7:0]  bad;
    pick = $urandom_range(99);
    len  = $urandom_range(MAX_SEQ_LEN_DEF, 2);
    lead = (8'hFF << (8 - len)) | (8'($urandom) & (LEAD_MASK >> len));
    if (pick < 25) begin
      send_byte(8'($urandom_range(127)), rare_eos());
    end else if (pick < 65) begin
      send_byte(lead, 1'b0);
      for (int unsigned i = 1; i < len; i++) begin
        send_byte(CONT_TAG | (8'($urandom) & PAY_MASK), (i == len - 1) && rare_eos());
      end
    end else if (pick < 80) begin
      // mostly broken: 0..len-2 continuations, then a bad byte or an end
      keep = $urandom_range(len - 2, 0);
      send_byte(lead, 1'b0);
      for (int unsigned i = 0; i < keep; i++) begin
        send_byte(CONT_TAG | (8'($urandom) & PAY_MASK), 1'b0);
      end
      if ($urandom_range(1) == 0) begin
        bad = 8'($urandom);
        if ((bad & CONT_MASK) == CONT_TAG) bad[7] = 1'b0;
        send_byte(bad, rare_eos());
      end else begin
        send_byte(CONT_TAG | (8'($urandom) & PAY_MASK), 1'b1);
      end
    end else if (pick < 90) begin
      send_byte(8'($urandom), rare_eos());
    end else if (pick < 95) begin
      send_byte(lead, 1'b1);
    end else begin
      send_byte(8'($urandom_range(255, 8'hF8)), rare_eos());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edge cases, no idling
    foreach (edge_cases[i]) send_byte(edge_cases[i][7:0], edge_cases[i][8]);
    drain();

    // phase 1: sender idles less than the receiver stalls
    send_idle_pct  = 32;
    recv_stall_pct = 51;
    while (bytes_sent < 75) send_random_unit();
    drain();

    // phase 2: the other way round
    send_idle_pct  = 51;
    recv_stall_pct = 32;
    while (bytes_sent < 120) send_random_unit();
    drain();

    // phase 3: back to back on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (bytes_sent < 165) send_random_unit();
    drain();

    // settle: margin for any stray output
    repeat (8) @(posedge clk);

    $display("run: %0d bytes in (edge cases, then random UTF-8 with broken and cut-short runs)",
             bytes_sent);
    $display("run: %0d results compared, %0d errors", checked, err_count);
    if (err_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
